// ===== sv/crp_pkg.sv =====
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the A1 cell/range reference parser.
// ----------------------------------------------------------------------------
package crp_pkg;

	// one request on the character channel
	typedef struct packed {
		logic [7:0] character;
		logic       start_req;
	} char_req_t;

	// one parsed reference on the result channel
	typedef struct packed {
		logic [4:0]  ref_code;
		logic [15:0] low_row;
		logic [15:0] high_row;
		logic [9:0]  low_col;
		logic [9:0]  high_col;
		logic [7:0]  length_used;
	} ref_result_t;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_DOLLAR,
		CLS_LETTER,
		CLS_DIGIT,
		CLS_SEP
	} char_class_t;

	// classified character as it travels from front to back
	typedef struct packed {
		logic        start;
		char_class_t cls;
		logic [4:0]  val;
	} char_tok_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [4:0] CODE_NONE  = 5'd0;
	localparam logic [4:0] CODE_CELL  = 5'd12;
	localparam logic [4:0] CODE_RANGE = 5'd16;

	localparam int         ALPHA_SIZE = 26;
	localparam int         RADIX      = 10;
	localparam logic [7:0] USED_MAX   = 8'd255;

endpackage

// ===== sv/crp_chan_if.sv =====
// ----------------------------------------------------------------------------
// crp_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface crp_chan_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/a1_cell_range_ref_parser.sv =====
// ----------------------------------------------------------------------------
// a1_cell_range_ref_parser
// A1-style cell and range reference recogniser, one character per request.
//
// Characters enter on the chars channel; a request with start_req set begins
// a candidate reference such as $A$1 or B5:C10. The first character that does
// not fit ends the candidate and one result leaves on the refs channel. A
// classifier takes one character per cycle into a four-entry token queue, and
// the grammar state machine retires one token per cycle, so the sustained
// rate is one character per cycle; the result of the ending character passes
// through the token queue and the result register before it is valid on refs.
// The parser stalls only when a result is pending and the refs side is not
// ready; the chars side then stalls once the queue is full.
// ----------------------------------------------------------------------------
module a1_cell_range_ref_parser #(
	parameter int MAX_COLUMN  = 702,
	parameter int MAX_ROW_NUM = 65535,
	parameter int MIN_COLUMN  = 1,
	parameter int MIN_ROW_NUM = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	crp_chan_if.sink   chars,
	crp_chan_if.source refs
);
	import crp_pkg::*;

	logic      push;
	logic      full;
	logic      pop;
	logic      not_empty;
	char_tok_t push_tok;
	char_tok_t pop_tok;

	crp_front u_front (
		.chars (chars),
		.full  (full),
		.push  (push),
		.tok   (push_tok)
	);

	crp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_tok   (pop_tok)
	);

	crp_back #(
		.MAX_COLUMN  (MAX_COLUMN),
		.MAX_ROW_NUM (MAX_ROW_NUM),
		.MIN_COLUMN  (MIN_COLUMN),
		.MIN_ROW_NUM (MIN_ROW_NUM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (not_empty),
		.tok       (pop_tok),
		.pop       (pop),
		.refs      (refs)
	);
endmodule

// ===== sv/crp_front.sv =====
// ----------------------------------------------------------------------------
// crp_front
// Accepts characters and classifies them into tokens for the queue.
// ----------------------------------------------------------------------------
module crp_front (
	crp_chan_if.sink          chars,
	input  logic              full,
	output logic              push,
	output crp_pkg::char_tok_t tok
);
	import crp_pkg::*;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	logic [7:0] ch;
	logic [7:0] diff_up;
	logic [7:0] diff_lo;
	logic [7:0] diff_dig;

	assign ch       = chars.payload.character;
	assign diff_up  = ch - CH_UP_A;
	assign diff_lo  = ch - CH_LO_A;
	assign diff_dig = ch - CH_0;

	assign chars.ready = !full;
	assign push        = chars.valid && !full;

	always_comb begin
		tok.start = chars.payload.start_req;
		tok.cls   = CLS_OTHER;
		tok.val   = '0;
		if (ch == CH_DOLLAR) begin
			tok.cls = CLS_DOLLAR;
		end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			tok.cls = CLS_LETTER;
			tok.val = diff_up[4:0];
		end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
			tok.cls = CLS_LETTER;
			tok.val = diff_lo[4:0];
		end else if (ch >= CH_0 && ch <= CH_9) begin
			tok.cls = CLS_DIGIT;
			tok.val = diff_dig[4:0];
		end else if (ch == CH_COLON || ch == CH_DOT) begin
			tok.cls = CLS_SEP;
		end
	end
endmodule

// ===== sv/crp_queue.sv =====
// ----------------------------------------------------------------------------
// crp_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module crp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  crp_pkg::char_tok_t push_tok,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output crp_pkg::char_tok_t pop_tok
);
	import crp_pkg::*;

	char_tok_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_tok   = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== sv/crp_back.sv =====
// ----------------------------------------------------------------------------
// crp_back
// Reference grammar state machine with a registered result stage.
// ----------------------------------------------------------------------------
module crp_back #(
	parameter int MAX_COLUMN  = 702,
	parameter int MAX_ROW_NUM = 65535,
	parameter int MIN_COLUMN  = 1,
	parameter int MIN_ROW_NUM = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	input  crp_pkg::char_tok_t tok,
	output logic               pop,
	crp_chan_if.source         refs
);
	import crp_pkg::*;

	typedef enum logic [2:0] {
		P_IDLE,
		P_START,
		P_LETTER,
		P_COL,
		P_NEEDDIG,
		P_ROW
	} phase_t;

	localparam logic [9:0]  MIN_C   = 10'(MIN_COLUMN);
	localparam logic [9:0]  MAX_C   = 10'(MAX_COLUMN);
	localparam logic [16:0] MIN_R   = 17'(MIN_ROW_NUM);
	localparam logic [16:0] MAX_R   = 17'(MAX_ROW_NUM);
	localparam logic [16:0] ROW_CAP = 17'(MAX_ROW_NUM + 1);

	phase_t      phase_q;
	logic        cell2_q;
	logic [9:0]  col_q;
	logic [1:0]  letters_q;
	logic [16:0] row_q;
	logic [9:0]  fcol_q;
	logic [15:0] frow_q;
	logic [3:0]  rel_q;
	logic [7:0]  used_q;
	logic        out_valid_q;
	ref_result_t out_res_q;

	phase_t      c_phase, n_phase;
	logic        c_cell2, n_cell2;
	logic [9:0]  c_col, n_col;
	logic [1:0]  c_letters, n_letters;
	logic [16:0] c_row, n_row;
	logic [9:0]  c_fcol, n_fcol;
	logic [15:0] c_frow, n_frow;
	logic [3:0]  c_rel, n_rel;
	logic [7:0]  c_used, n_used;

	logic [3:0]  colbit, rowbit;
	logic [15:0] col_mac;
	logic [9:0]  added_col;
	logic [20:0] row_mac;
	logic [16:0] row_next;
	logic [7:0]  used_inc;
	logic        col_ok, row_ok;
	logic        is_letter, is_digit;
	logic        emit;
	logic        slot_free;
	ref_result_t res;

	assign slot_free = !out_valid_q || refs.ready;
	assign pop       = tok_valid && (slot_free || !emit);

	assign refs.valid   = out_valid_q;
	assign refs.payload = out_res_q;

	always_comb begin
		// a start request restarts the candidate at this character
		if (tok.start) begin
			c_phase   = P_START;
			c_cell2   = 1'b0;
			c_col     = '0;
			c_letters = '0;
			c_row     = '0;
			c_fcol    = '0;
			c_frow    = '0;
			c_rel     = 4'd3;
			c_used    = '0;
		end else begin
			c_phase   = phase_q;
			c_cell2   = cell2_q;
			c_col     = col_q;
			c_letters = letters_q;
			c_row     = row_q;
			c_fcol    = fcol_q;
			c_frow    = frow_q;
			c_rel     = rel_q;
			c_used    = used_q;
		end

		is_letter = tok.cls == CLS_LETTER;
		is_digit  = tok.cls == CLS_DIGIT;
		colbit    = c_cell2 ? 4'd8 : 4'd2;
		rowbit    = c_cell2 ? 4'd2 : 4'd1;

		col_mac = 16'(c_col - MIN_C) * 16'(ALPHA_SIZE) + 16'(MIN_C)
			+ 16'(ALPHA_SIZE) + 16'(tok.val);
		added_col = (c_letters == 2'd0) ? MIN_C + 10'(tok.val) : col_mac[9:0];

		row_mac  = 21'(c_row) * 21'(RADIX) + 21'(tok.val);
		row_next = (row_mac > 21'(ROW_CAP)) ? ROW_CAP : row_mac[16:0];
		used_inc = (c_used == USED_MAX) ? c_used : c_used + 1'b1;

		col_ok = c_col >= MIN_C && c_col <= MAX_C;
		row_ok = c_row >= MIN_R && c_row <= MAX_R;

		n_phase   = c_phase;
		n_cell2   = c_cell2;
		n_col     = c_col;
		n_letters = c_letters;
		n_row     = c_row;
		n_fcol    = c_fcol;
		n_frow    = c_frow;
		n_rel     = c_rel;
		n_used    = c_used;
		emit      = 1'b0;
		res       = '0;

		case (c_phase)
			P_START, P_LETTER: begin
				if (c_phase == P_START && tok.cls == CLS_DOLLAR) begin
					n_rel   = c_rel & ~colbit;
					n_phase = P_LETTER;
					n_used  = used_inc;
				end else if (!is_letter) begin
					n_phase = P_IDLE;
					emit    = 1'b1;
				end else begin
					n_col     = added_col;
					n_letters = c_letters + 1'b1;
					n_used    = used_inc;
					n_phase   = P_COL;
				end
			end
			P_COL: begin
				if (is_letter) begin
					if (c_letters >= 2'd2) begin
						n_phase = P_IDLE;
						emit    = 1'b1;
					end else begin
						n_col     = added_col;
						n_letters = c_letters + 1'b1;
						n_used    = used_inc;
					end
				end else if (!col_ok) begin
					n_phase = P_IDLE;
					emit    = 1'b1;
				end else if (tok.cls == CLS_DOLLAR) begin
					n_rel   = c_rel & ~rowbit;
					n_phase = P_NEEDDIG;
					n_used  = used_inc;
				end else if (!is_digit) begin
					n_phase = P_IDLE;
					emit    = 1'b1;
				end else begin
					n_row   = 17'(tok.val);
					n_phase = P_ROW;
					n_used  = used_inc;
				end
			end
			P_NEEDDIG: begin
				if (!is_digit) begin
					n_phase = P_IDLE;
					emit    = 1'b1;
				end else begin
					n_row   = 17'(tok.val);
					n_phase = P_ROW;
					n_used  = used_inc;
				end
			end
			P_ROW: begin
				if (is_digit) begin
					n_row  = row_next;
					n_used = used_inc;
				end else if (!row_ok) begin
					n_phase = P_IDLE;
					emit    = 1'b1;
				end else if (!c_cell2 && tok.cls == CLS_SEP) begin
					// hand the first cell over and remap its relative bits
					n_frow    = c_row[15:0];
					n_fcol    = c_col;
					n_rel     = {1'b1, c_rel[1], 1'b1, c_rel[0]};
					n_col     = '0;
					n_letters = '0;
					n_row     = '0;
					n_cell2   = 1'b1;
					n_phase   = P_START;
					n_used    = used_inc;
				end else if (!c_cell2) begin
					n_phase         = P_IDLE;
					emit            = 1'b1;
					res.ref_code    = CODE_CELL + {3'b000, c_rel[1:0]};
					res.low_row     = c_row[15:0];
					res.high_row    = c_row[15:0];
					res.low_col     = c_col;
					res.high_col    = c_col;
					res.length_used = c_used;
				end else begin
					n_phase         = P_IDLE;
					emit            = 1'b1;
					res.ref_code    = CODE_RANGE + {1'b0, c_rel};
					res.low_row     = (c_frow < c_row[15:0]) ? c_frow : c_row[15:0];
					res.high_row    = (c_frow < c_row[15:0]) ? c_row[15:0] : c_frow;
					res.low_col     = (c_fcol < c_col) ? c_fcol : c_col;
					res.high_col    = (c_fcol < c_col) ? c_col : c_fcol;
					res.length_used = c_used;
				end
			end
			default: begin
				// idle: drop the character
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			cell2_q     <= 1'b0;
			col_q       <= '0;
			letters_q   <= '0;
			row_q       <= '0;
			fcol_q      <= '0;
			frow_q      <= '0;
			rel_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= n_phase;
				cell2_q   <= n_cell2;
				col_q     <= n_col;
				letters_q <= n_letters;
				row_q     <= n_row;
				fcol_q    <= n_fcol;
				frow_q    <= n_frow;
				rel_q     <= n_rel;
				used_q    <= n_used;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
				out_res_q   <= res;
			end else if (refs.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		refs.valid && refs.payload.ref_code == CODE_NONE |->
		refs.payload.low_row == '0 && refs.payload.high_row == '0 &&
		refs.payload.low_col == '0 && refs.payload.high_col == '0 &&
		refs.payload.length_used == '0)
		else $error("failed reference carries non-zero fields");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		refs.valid && refs.payload.ref_code != CODE_NONE |->
		refs.payload.low_row <= refs.payload.high_row &&
		refs.payload.low_col <= refs.payload.high_col)
		else $error("reference bounds not sorted");

	a_cell_equal: assert property (@(posedge clk) disable iff (!arst_n)
		refs.valid && refs.payload.ref_code >= CODE_CELL &&
		refs.payload.ref_code < CODE_RANGE |->
		refs.payload.low_row == refs.payload.high_row &&
		refs.payload.low_col == refs.payload.high_col)
		else $error("single cell with unequal bounds");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && emit |=> phase_q == P_IDLE && out_valid_q)
		else $error("result issued without returning to idle");
`endif
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the A1 cell/range reference parser. A table of
// hand-picked references and failures runs first, then random candidates,
// noise and corrupted text. Every accepted character goes through a local
// scanner that tracks the grammar state and queues the result it expects.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import crp_pkg::*;

	localparam int MAX_COLUMN   = 702;
	localparam int MAX_ROW_NUM  = 65535;
	localparam int MIN_COLUMN   = 1;
	localparam int MIN_ROW_NUM  = 1;
	localparam int RANDOM_ITEMS = 220;
	localparam int WATCHDOG     = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LETTER,
		ST_COL,
		ST_NEEDDIG,
		ST_ROW
	} scan_step_t;

	typedef struct {
		char_req_t   req;
		bit          typed;
		ref_result_t want;
	} stim_t;

	typedef struct {
		string text;
		int    start_at;
		int    term;
		bit    typed;
		int    code;
		int    r0;
		int    r1;
		int    c0;
		int    c1;
		int    len;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	crp_chan_if #(.payload_t(char_req_t))   chars_if ();
	crp_chan_if #(.payload_t(ref_result_t)) refs_if ();

	a1_cell_range_ref_parser dut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars_if),
		.refs  (refs_if)
	);

	always #5 clk = ~clk;

	// scanner state
	scan_step_t  sc_step      = ST_IDLE;
	bit          sc_second    = 1'b0;
	logic [9:0]  sc_col       = '0;
	logic [1:0]  sc_letters   = '0;
	logic [16:0] sc_row       = '0;
	logic [9:0]  sc_first_col = '0;
	logic [15:0] sc_first_row = '0;
	logic [3:0]  sc_rel       = '0;
	logic [7:0]  sc_used      = '0;

	stim_t       stim_q[$];
	ref_result_t ref_exp_q[$];
	stim_t       drive_item;
	bit          start_next;
	bit          corrupt_on;
	bit          chars_burst;
	bit          refs_burst;
	int          errors;
	int          idle_cycles;

	function automatic bit is_letter(logic [7:0] ch);
		return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
	endfunction

	function automatic bit is_digit(logic [7:0] ch);
		return ch >= "0" && ch <= "9";
	endfunction

	function automatic ref_result_t make_ref(int code, int r0, int r1, int c0, int c1,
			int len);
		ref_result_t r;
		r.ref_code    = 5'(code);
		r.low_row     = 16'((r0 < r1) ? r0 : r1);
		r.high_row    = 16'((r0 < r1) ? r1 : r0);
		r.low_col     = 10'((c0 < c1) ? c0 : c1);
		r.high_col    = 10'((c0 < c1) ? c1 : c0);
		r.length_used = 8'(len);
		return r;
	endfunction

	function automatic void bump_used();
		if (sc_used < USED_MAX)
			sc_used++;
	endfunction

	function automatic void add_letter(logic [7:0] ch);
		int v;
		v = (ch >= "a") ? int'(ch) - int'("a") : int'(ch) - int'("A");
		if (sc_letters == 0)
			sc_col = 10'(MIN_COLUMN + v);
		else
			sc_col = 10'((int'(sc_col) - MIN_COLUMN) * ALPHA_SIZE + MIN_COLUMN + ALPHA_SIZE + v);
		sc_letters++;
		bump_used();
	endfunction

	function automatic void begin_row(logic [7:0] ch);
		sc_row  = 17'(int'(ch) - int'("0"));
		sc_step = ST_ROW;
		bump_used();
	endfunction

	// Advance the scanner by one character; returns 1 when a result leaves.
	// A failure returns with every field left at zero.
	function automatic bit scan_ref_char(input char_req_t req, output ref_result_t res);
		logic [7:0] ch;
		logic [3:0] colbit;
		logic [3:0] rowbit;
		int         num;
		res = '0;
		ch  = req.character;
		if (req.start_req) begin
			sc_step      = ST_START;
			sc_second    = 1'b0;
			sc_col       = '0;
			sc_letters   = '0;
			sc_row       = '0;
			sc_first_col = '0;
			sc_first_row = '0;
			sc_rel       = 4'd3;
			sc_used      = '0;
		end
		if (sc_step == ST_IDLE)
			return 1'b0;
		colbit = sc_second ? 4'd8 : 4'd2;
		rowbit = sc_second ? 4'd2 : 4'd1;
		case (sc_step)
			ST_START, ST_LETTER: begin
				if (sc_step == ST_START && ch == "$") begin
					sc_rel &= ~colbit;
					sc_step = ST_LETTER;
					bump_used();
					return 1'b0;
				end
				if (!is_letter(ch)) begin
					sc_step = ST_IDLE;
					return 1'b1;
				end
				add_letter(ch);
				sc_step = ST_COL;
				return 1'b0;
			end
			ST_COL: begin
				if (is_letter(ch)) begin
					if (sc_letters >= 2) begin
						sc_step = ST_IDLE;
						return 1'b1;
					end
					add_letter(ch);
					return 1'b0;
				end
				if (sc_col < MIN_COLUMN || sc_col > MAX_COLUMN || (ch != "$" && !is_digit(ch))) begin
					sc_step = ST_IDLE;
					return 1'b1;
				end
				if (ch == "$") begin
					sc_rel &= ~rowbit;
					sc_step = ST_NEEDDIG;
					bump_used();
					return 1'b0;
				end
				begin_row(ch);
				return 1'b0;
			end
			ST_NEEDDIG: begin
				if (!is_digit(ch)) begin
					sc_step = ST_IDLE;
					return 1'b1;
				end
				begin_row(ch);
				return 1'b0;
			end
			default: begin
				if (is_digit(ch)) begin
					// saturate one above the largest row so the range check fails
					num = int'(sc_row) * RADIX + int'(ch) - int'("0");
					if (num > MAX_ROW_NUM + 1)
						num = MAX_ROW_NUM + 1;
					sc_row = 17'(num);
					bump_used();
					return 1'b0;
				end
				if (sc_row < MIN_ROW_NUM || sc_row > MAX_ROW_NUM) begin
					sc_step = ST_IDLE;
					return 1'b1;
				end
				if (!sc_second && (ch == ":" || ch == ".")) begin
					sc_first_row = sc_row[15:0];
					sc_first_col = sc_col;
					// move the first cell's bits to the range layout
					sc_rel     = {1'b1, sc_rel[1], 1'b1, sc_rel[0]};
					sc_col     = '0;
					sc_letters = '0;
					sc_row     = '0;
					sc_second  = 1'b1;
					sc_step    = ST_START;
					bump_used();
					return 1'b0;
				end
				sc_step = ST_IDLE;
				if (!sc_second)
					res = make_ref(CODE_CELL + sc_rel[1:0], sc_row, sc_row, sc_col, sc_col, sc_used);
				else
					res = make_ref(CODE_RANGE + sc_rel, sc_first_row, sc_row, sc_first_col, sc_col,
						sc_used);
				return 1'b1;
			end
		endcase
	endfunction

	function automatic void add_char(logic [7:0] ch, bit typed, ref_result_t want);
		stim_t s;
		s.req.character = ch;
		s.req.start_req = start_next;
		s.typed         = typed;
		s.want          = want;
		stim_q.push_back(s);
		start_next = 1'b0;
	endfunction

	function automatic void put_rand(logic [7:0] ch);
		if (corrupt_on && $urandom_range(0, 24) == 0)
			ch = 8'($urandom);
		add_char(ch, 1'b0, '0);
	endfunction

	function automatic void gen_cell();
		int         nlet;
		int         nz;
		string      digits;
		logic [7:0] base;
		if ($urandom_range(0, 1))
			put_rand("$");
		nlet = ($urandom_range(0, 11) == 0) ? 3 : $urandom_range(1, 2);
		repeat (nlet) begin
			base = $urandom_range(0, 1) ? "a" : "A";
			put_rand(base + 8'($urandom_range(0, 25)));
		end
		if ($urandom_range(0, 1))
			put_rand("$");
		case ($urandom_range(0, 9))
			0: digits = "1";
			1: digits = "65535";
			2: digits = "65536";
			3: digits = "0";
			4: digits = "";
			5: digits = $sformatf("%0d", $urandom_range(100000, 9999999));
			6, 7: digits = $sformatf("%0d", $urandom_range(1, 99));
			default: digits = $sformatf("%0d", $urandom_range(1, 65535));
		endcase
		nz = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
		repeat (nz)
			put_rand("0");
		for (int i = 0; i < digits.len(); i++)
			put_rand(digits[i]);
	endfunction

	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// sample both channels mid-cycle, where nothing moves
	always @(negedge clk) begin
		ref_result_t predicted;
		ref_result_t want;
		ref_result_t got;
		bit          req_fire;
		bit          ref_fire;
		req_fire = arst_n && chars_if.valid && chars_if.ready;
		ref_fire = arst_n && refs_if.valid && refs_if.ready;
		if (req_fire && scan_ref_char(chars_if.payload, predicted))
			ref_exp_q.push_back(drive_item.typed ? drive_item.want : predicted);
		if (ref_fire) begin
			got = refs_if.payload;
			if (ref_exp_q.size() == 0) begin
				$error("result with none expected: ref_code %0d", got.ref_code);
				errors++;
			end else begin
				want = ref_exp_q.pop_front();
				check_field("ref_code", want.ref_code, got.ref_code);
				check_field("low_row", want.low_row, got.low_row);
				check_field("high_row", want.high_row, got.high_row);
				check_field("low_col", want.low_col, got.low_col);
				check_field("high_col", want.high_col, got.high_col);
				check_field("length_used", want.length_used, got.length_used);
			end
		end
		if (req_fire || ref_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	// result side: stall at random between requests
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(refs_burst);
			if (stall > 0) begin
				refs_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			refs_if.ready <= 1'b1;
			@(negedge clk);
			while (!refs_if.valid)
				@(negedge clk);
			@(posedge clk);
		end
	end

	initial begin
		dir_row_t dir_tab[$];
		string    zeros;
		int       gap;
		int       dir_count;
		int       len;

		arst_n           = 1'b0;
		chars_if.valid   <= 1'b0;
		chars_if.payload <= '0;
		refs_if.ready    <= 1'b0;

		zeros = "";
		repeat (300)
			zeros = {zeros, "0"};
		dir_tab = '{
			'{"$A$1", 0, " ", 1, CODE_CELL, 1, 1, 1, 1, 4},
			'{"ZZ65535", 0, ";", 1, CODE_CELL + 3, 65535, 65535, 702, 702, 7},
			'{"zz65536", 0, " ", 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"A0", 0, " ", 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"ABC1", 0, -1, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"1A", 0, -1, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"$1", 0, -1, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"A$x", 0, -1, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"B5:C10", 0, 0, 1, CODE_RANGE + 15, 5, 10, 2, 3, 6},
			'{"$C$10.$B$5", 0, ")", 1, CODE_RANGE, 5, 10, 2, 3, 10},
			'{"A1:", 0, " ", 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"A1:B", 0, ";", 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"A99999999", 0, " ", 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"AB", 0, -1, 0, 0, 0, 0, 0, 0, 0},
			'{"$C3", 0, " ", 1, CODE_CELL + 1, 3, 3, 3, 3, 3},
			'{"q7 A1", 3, ";", 1, CODE_CELL + 3, 1, 1, 1, 1, 2},
			'{"$ZZ$65535", 0, ",", 1, CODE_CELL, 65535, 65535, 702, 702, 9},
			'{"AZ1.BA2", 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{"D9:A1", 0, " ", 1, CODE_RANGE + 15, 1, 9, 1, 4, 5},
			'{"A1$", 0, -1, 1, CODE_CELL + 3, 1, 1, 1, 1, 2},
			'{"A$$1", 0, -1, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"A1:B2:", 0, -1, 0, 0, 0, 0, 0, 0, 0},
			'{"", 0, 0, 1, CODE_NONE, 0, 0, 0, 0, 0},
			'{"a1:$b$2", 0, 255, 0, 0, 0, 0, 0, 0, 0}
		};
		// long run of leading zeros saturates the used count
		dir_tab.push_back('{{"A", zeros, "7"}, 0, " ", 1, CODE_CELL + 3, 7, 7, 1, 1, USED_MAX});

		foreach (dir_tab[r]) begin
			len = dir_tab[r].text.len();
			for (int i = 0; i <= len; i++) begin
				start_next = (i == dir_tab[r].start_at);
				if (i < len || dir_tab[r].term >= 0)
					add_char((i < len) ? dir_tab[r].text[i] : 8'(dir_tab[r].term), dir_tab[r].typed,
						make_ref(dir_tab[r].code, dir_tab[r].r0, dir_tab[r].r1, dir_tab[r].c0,
							dir_tab[r].c1, dir_tab[r].len));
			end
		end
		dir_count = stim_q.size();

		// mostly well-formed candidates, some corrupted, some pure noise
		while (stim_q.size() < dir_count + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					corrupt_on = 1'b0;
					repeat ($urandom_range(1, 6)) begin
						start_next = ($urandom_range(0, 3) == 0);
						add_char(8'($urandom), 1'b0, '0);
					end
				end
				default: begin
					corrupt_on = ($urandom_range(0, 5) == 0);
					start_next = 1'b1;
					gen_cell();
					if ($urandom_range(0, 2) == 0) begin
						put_rand($urandom_range(0, 1) ? ":" : ".");
						gen_cell();
					end
					// leave some open so the next start drops them
					case ($urandom_range(0, 7))
						0: ;
						1: put_rand(8'd0);
						2: put_rand(" ");
						3: put_rand(";");
						4: put_rand(")");
						default: put_rand(8'($urandom));
					endcase
				end
			endcase
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		fork
			begin
				foreach (stim_q[n]) begin
					gap = draw_wait(chars_burst);
					if (gap > 0) begin
						chars_if.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					drive_item = stim_q[n];
					chars_if.valid   <= 1'b1;
					chars_if.payload <= stim_q[n].req;
					@(negedge clk);
					while (!chars_if.ready)
						@(negedge clk);
					@(posedge clk);
				end
				chars_if.valid <= 1'b0;
				while (ref_exp_q.size() != 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG);
		join_any

		if (idle_cycles >= WATCHDOG)
			$display("a1_cell_range_ref_parser: mismatch");
		else if (errors == 0)
			$display("a1_cell_range_ref_parser: match");
		else
			$display("a1_cell_range_ref_parser: mismatch");
		$finish;
	end

endmodule
